FILE: rtl/core/huber_loss_and_gradient_defines.svh
// Assertion macros shared by the Huber loss checker.
`ifndef HUBER_LOSS_AND_GRADIENT_DEFINES_SVH
`define HUBER_LOSS_AND_GRADIENT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define HLG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define HLG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that looks at reset itself.
`define HLG_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/hlg_pkg.sv
`default_nettype none

package hlg_pkg;

  localparam int DELTA_W  = 31;  // huber_delta
  localparam int CNT_W    = 21;  // element_count
  localparam int DATA_W   = 32;  // prediction, target_value, gradient
  localparam int MAG_W    = 33;  // |prediction - target_value|
  localparam int OPB_W    = 34;  // second multiplier operand, up to 2*|d|
  localparam int HALF_W   = 17;  // operand B is multiplied in two halves
  localparam int PROD_W   = 48;  // 31 x 17 partial product
  localparam int ACC_W    = 48;
  localparam int TOTAL_W  = 47;
  localparam int DIV_W    = 48;  // divider dividend / quotient
  localparam int STEP_W   = $clog2(DIV_W);
  localparam int IDX_W    = 2;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;

  localparam logic [IDX_W-1:0] REG_DELTA = 2'd0;
  localparam logic [IDX_W-1:0] REG_MODE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_COUNT = 2'd2;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic               mean;    // 1: mean reduction, 0: sum
    logic [CNT_W-1:0]   count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{delta: 31'd65536, mean: 1'b1, count: 21'd1};

  // One classified element on its way from front to back
  typedef struct packed {
    logic             neg;
    logic             quad;   // |d| <= delta
    logic [MAG_W-1:0] mag;
  } q_entry_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/hlg_front.sv
`default_nettype none

module hlg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [hlg_pkg::DATA_W-1:0] prediction,
  input  logic signed [hlg_pkg::DATA_W-1:0] target_value,
  input  logic [hlg_pkg::DELTA_W-1:0]   delta,
  input  logic                          q_full,
  output logic                          q_push,
  output hlg_pkg::q_entry_t             q_wdata
);
  import hlg_pkg::*;

  logic             stage_valid;
  logic [MAG_W-1:0] diff;
  logic [MAG_W-1:0] mag;
  logic             accept;

  assign q_push   = stage_valid && !q_full;
  assign in_stall = stage_valid && q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (q_push) begin
      stage_valid <= 1'b0;
    end
  end

  // exact 33-bit difference
  always_ff @(posedge clk) begin
    if (accept) begin
      diff <= {prediction[DATA_W-1], prediction} - {target_value[DATA_W-1], target_value};
    end
  end

  assign mag = diff[MAG_W-1] ? (MAG_W'(0) - diff) : diff;

  assign q_wdata.neg  = diff[MAG_W-1];
  assign q_wdata.quad = (mag <= {{(MAG_W-DELTA_W){1'b0}}, delta});
  assign q_wdata.mag  = mag;

endmodule

`default_nettype wire

FILE: rtl/core/hlg_queue.sv
`default_nettype none

module hlg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hlg_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output hlg_pkg::q_entry_t rdata
);
  import hlg_pkg::*;

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

FILE: rtl/core/hlg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module hlg_div (
  input  logic              clk,
  input  logic              rst,
  input  hlg_pkg::div_req_t req,
  output hlg_pkg::div_rsp_t rsp
);
  import hlg_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [DIV_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  assign rem_shift = {rem, quo[DIV_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs};
  assign fits      = (rem_shift >= {1'b0, dvs});

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo   <= req.dividend;
      rem   <= '0;
      dvs   <= req.divisor;
      steps <= LAST_STEP;
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (fits) begin
        rem <= rem_diff[CNT_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[CNT_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hlg_back.sv
`default_nettype none

module hlg_back #(
  parameter int unsigned COUNT_LIMIT = 1048576
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hlg_pkg::cfg_t                     cfg,
  input  logic                              q_empty,
  input  hlg_pkg::q_entry_t                 q_data,
  output logic                              q_pop,
  output hlg_pkg::div_req_t                 div_req,
  input  hlg_pkg::div_rsp_t                 div_rsp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hlg_pkg::DATA_W-1:0] gradient,
  output logic [hlg_pkg::TOTAL_W-1:0]       loss_total,
  output logic                              last
);
  import hlg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_MUL_LO = 4'd2;
  localparam logic [3:0] S_MUL_HI = 4'd3;
  localparam logic [3:0] S_SUM    = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_GDIV   = 4'd6;
  localparam logic [3:0] S_TDIV   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]         state;
  logic [3:0]         state_next;

  logic               ent_neg;
  logic               ent_quad;
  logic [MAG_W-1:0]   ent_mag;
  logic [DELTA_W-1:0] a_op;
  logic [OPB_W-1:0]   b_op;
  logic [DELTA_W-1:0] gmag;
  logic [PROD_W-1:0]  prod_lo;
  logic [PROD_W-1:0]  prod_hi;
  logic [ACC_W-1:0]   eloss;
  logic [ACC_W-1:0]   acc;
  logic [CNT_W-1:0]   seen;
  logic               is_last;
  logic [ACC_W-1:0]   tot_src;
  logic [DIV_W-1:0]   total;

  logic [CNT_W-1:0]   cnt;
  logic [HALF_W-1:0]  mul_b;
  logic [PROD_W-1:0]  product;
  logic [ACC_W:0]     sum_ext;
  logic [ACC_W-1:0]   acc_new;
  logic [CNT_W-1:0]   seen_inc;
  logic               last_now;
  logic               need_div;
  logic               out_free;

  // effective pass length: zero acts as one, clamp at the limit
  always_comb begin
    if (cfg.count == '0) begin
      cnt = CNT_W'(1);
    end else if (32'(cfg.count) > 32'(COUNT_LIMIT)) begin
      cnt = CNT_W'(COUNT_LIMIT);
    end else begin
      cnt = cfg.count;
    end
  end

  assign need_div = cfg.mean && (cnt != CNT_W'(1));
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  // one shared 31x17 multiplier, low half then high half of operand B
  assign mul_b   = (state == S_MUL_LO) ? b_op[HALF_W-1:0] : b_op[OPB_W-1:HALF_W];
  assign product = {{(PROD_W-DELTA_W){1'b0}}, a_op} * {{(PROD_W-HALF_W){1'b0}}, mul_b};

  assign sum_ext  = {1'b0, acc} + {1'b0, eloss};
  assign acc_new  = sum_ext[ACC_W] ? {ACC_W{1'b1}} : sum_ext[ACC_W-1:0];
  assign seen_inc = seen + 1'b1;
  assign last_now = (seen_inc >= cnt);

  assign div_req.start    = ((state == S_ACC) && need_div)
                          || ((state == S_GDIV) && div_rsp.done && is_last);
  assign div_req.dividend = (state == S_ACC) ? DIV_W'(gmag) : tot_src;
  assign div_req.divisor  = cnt;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (!q_empty) state_next = S_PREP;
      S_PREP:   state_next = S_MUL_LO;
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_SUM;
      S_SUM:    state_next = S_ACC;
      S_ACC:    state_next = need_div ? S_GDIV : S_OUT;
      S_GDIV:   if (div_rsp.done) state_next = is_last ? S_TDIV : S_OUT;
      S_TDIV:   if (div_rsp.done) state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      acc       <= '0;
      seen      <= '0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_ACC) begin
        if (last_now) begin
          acc  <= '0;
          seen <= '0;
        end else begin
          acc  <= acc_new;
          seen <= seen_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ent_neg  <= q_data.neg;
        ent_quad <= q_data.quad;
        ent_mag  <= q_data.mag;
      end
      S_PREP: begin
        if (ent_quad) begin
          a_op <= ent_mag[DELTA_W-1:0];
          b_op <= {1'b0, ent_mag};
          gmag <= ent_mag[DELTA_W-1:0];
        end else begin
          a_op <= cfg.delta;
          b_op <= {ent_mag, 1'b0} - {{(OPB_W-DELTA_W){1'b0}}, cfg.delta};
          gmag <= cfg.delta;
        end
      end
      S_MUL_LO: prod_lo <= product;
      S_MUL_HI: prod_hi <= product;
      // (hi * 2^17 + lo) >> 17
      S_SUM:    eloss <= prod_hi + {{HALF_W{1'b0}}, prod_lo[PROD_W-1:HALF_W]};
      S_ACC: begin
        is_last <= last_now;
        tot_src <= acc_new;
        total   <= acc_new;
      end
      S_GDIV: if (div_rsp.done) gmag <= div_rsp.quotient[DELTA_W-1:0];
      S_TDIV: if (div_rsp.done) total <= div_rsp.quotient;
      S_OUT: begin
        if (out_free) begin
          gradient <= ent_neg ? (DATA_W'(0) - {1'b0, gmag}) : {1'b0, gmag};
          last     <= is_last;
          if (!is_last) begin
            loss_total <= '0;
          end else if (total[DIV_W-1]) begin
            loss_total <= {TOTAL_W{1'b1}};
          end else begin
            loss_total <= total[TOTAL_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/huber_loss_and_gradient.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | prediction, target_value (Q16.16 signed)
// out     | output    | out_valid/out_stall | gradient, loss_total, last
// cfg     | input     | cfg_write           | cfg_index, cfg_data (no read-back)
//
// Back end takes one element at a time through idle, prep, low and high multiply,
// sum, accumulate and output states in sum mode or with a pass length of one.
// Mean mode with a longer pass adds a gradient divide, and the element that closes
// the pass adds one for the total, both on the shared one-bit-per-cycle divider.
// Front end takes a transfer every cycle until its stage and the 2-entry queue fill.
// Reset clears accumulator, element count, queue and valids; config regs reload.
`default_nettype none

module huber_loss_and_gradient #(
  parameter int unsigned COUNT_LIMIT = 1048576
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_write,
  input  logic [hlg_pkg::IDX_W-1:0]         cfg_index,
  input  logic [hlg_pkg::DELTA_W-1:0]       cfg_data,
  // element stream in
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hlg_pkg::DATA_W-1:0] prediction,
  input  logic signed [hlg_pkg::DATA_W-1:0] target_value,
  // result stream out
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hlg_pkg::DATA_W-1:0] gradient,
  output logic [hlg_pkg::TOTAL_W-1:0]       loss_total,
  output logic                              last
);
  import hlg_pkg::*;

  cfg_t     cfg;
  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  q_entry_t q_wdata;
  q_entry_t q_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Config registers. Writes must only arrive while the block is idle (the block does
  // not enforce this), so the datapath reads them directly with no shadow copy.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DELTA: cfg.delta <= cfg_data;
        REG_MODE:  cfg.mean  <= cfg_data[0];
        REG_COUNT: cfg.count <= cfg_data[CNT_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Front: one register for the exact 33-bit difference, then abs and the
  // delta compare on the way into the queue.
  hlg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .prediction   (prediction),
    .target_value (target_value),
    .delta        (cfg.delta),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // Short queue decouples the classifier from the multi-cycle back end.
  hlg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // Back: element loss via split multiply, saturating accumulate, mean
  // divides, output register.
  hlg_back #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .gradient   (gradient),
    .loss_total (loss_total),
    .last       (last)
  );

  // Shared divider: gradient / count, then total / count on the closing element.
  hlg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/core/hlg_checker.sv
`default_nettype none
`include "huber_loss_and_gradient_defines.svh"

module hlg_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [hlg_pkg::DATA_W-1:0] gradient,
  input  logic [hlg_pkg::TOTAL_W-1:0]       loss_total,
  input  logic                              last
);

  // total only shows on the closing element
  `HLG_ASSERT_IMPLIES(a_total_only_on_last, clk, rst, out_valid && !last, loss_total == '0, "loss_total nonzero without last")

  // |gradient| <= delta < 2^31, so the most negative code never appears
  `HLG_ASSERT_IMPLIES(a_grad_range, clk, rst, out_valid, gradient != 32'sh8000_0000, "gradient out of range")

  `HLG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(gradient) && $stable(loss_total) && $stable(last), "stalled result changed")

  // nothing in flight and room for a transfer right after reset
  `HLG_ASSERT_AFTER_RESET(a_reset_clean, clk, rst, !out_valid && !in_stall, "state not cleared by reset")

endmodule

bind huber_loss_and_gradient hlg_checker u_checker (.*);

`default_nettype wire
